>>> sv/pc_power_button_sequencer_top_assert.svh
// Assertion macros shared by the sequencer modules.
`ifndef PC_POWER_BUTTON_SEQUENCER_TOP_ASSERT_SVH
`define PC_POWER_BUTTON_SEQUENCER_TOP_ASSERT_SVH

// Check a condition at every edge outside reset.
`define PBS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a condition implies another at the next edge.
`define PBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pbs_pkg.sv
package pbs_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 18;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned FORCE_W    = 18;
    localparam int unsigned PHASE_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_OPEN_PULSE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HOLD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_PULSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_OFF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT     = 3'd5;

    localparam logic [CNT_W-1:0]   RST_OPEN_PULSE  = 16'd500;
    localparam logic [CNT_W-1:0]   RST_KEY_HOLD    = 16'd2000;
    localparam logic [CNT_W-1:0]   RST_CLOSE_PULSE = 16'd500;
    localparam logic [FORCE_W-1:0] RST_FORCE_OFF   = 18'd40000;
    localparam logic [CNT_W-1:0]   RST_OFF_DELAY   = 16'd1000;
    localparam logic [CNT_W-1:0]   RST_LOCKOUT     = 16'd250;

    typedef struct packed {
        logic [CNT_W-1:0]   open_pulse_ticks;
        logic [CNT_W-1:0]   key_hold_ticks;
        logic [CNT_W-1:0]   close_pulse_ticks;
        logic [FORCE_W-1:0] force_off_ticks;
        logic [CNT_W-1:0]   off_delay_ticks;
        logic [CNT_W-1:0]   lockout_ticks;
    } t_cfg;

    typedef struct packed {
        logic               pc_enable_level;
        logic               supply_on;
        logic               open_done;
        logic [PHASE_W-1:0] phase;
    } t_res;

    function automatic logic [CNT_W-1:0] sat_inc16(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 16'd1;
    endfunction

    function automatic logic [FORCE_W-1:0] sat_inc18(input logic [FORCE_W-1:0] v);
        return (v == {FORCE_W{1'b1}}) ? v : v + 18'd1;
    endfunction

endpackage

>>> sv/pbs_cfg_regs.sv
module pbs_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [pbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pbs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output pbs_pkg::t_cfg                  o_cfg
);

    pbs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_pulse_ticks  <= pbs_pkg::RST_OPEN_PULSE;
            r_cfg.key_hold_ticks    <= pbs_pkg::RST_KEY_HOLD;
            r_cfg.close_pulse_ticks <= pbs_pkg::RST_CLOSE_PULSE;
            r_cfg.force_off_ticks   <= pbs_pkg::RST_FORCE_OFF;
            r_cfg.off_delay_ticks   <= pbs_pkg::RST_OFF_DELAY;
            r_cfg.lockout_ticks     <= pbs_pkg::RST_LOCKOUT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                pbs_pkg::REG_OPEN_PULSE: begin
                    r_cfg.open_pulse_ticks <= i_cfg_wdata[pbs_pkg::CNT_W-1:0];
                end
                pbs_pkg::REG_KEY_HOLD: begin
                    r_cfg.key_hold_ticks <= i_cfg_wdata[pbs_pkg::CNT_W-1:0];
                end
                pbs_pkg::REG_CLOSE_PULSE: begin
                    r_cfg.close_pulse_ticks <= i_cfg_wdata[pbs_pkg::CNT_W-1:0];
                end
                pbs_pkg::REG_FORCE_OFF: begin
                    r_cfg.force_off_ticks <= i_cfg_wdata[pbs_pkg::FORCE_W-1:0];
                end
                pbs_pkg::REG_OFF_DELAY: begin
                    r_cfg.off_delay_ticks <= i_cfg_wdata[pbs_pkg::CNT_W-1:0];
                end
                pbs_pkg::REG_LOCKOUT: begin
                    r_cfg.lockout_ticks <= i_cfg_wdata[pbs_pkg::CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/pbs_step.sv
`include "pc_power_button_sequencer_top_assert.svh"

module pbs_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_key_level,
    input  logic          i_pc_off_level,
    input  pbs_pkg::t_cfg i_cfg,
    output pbs_pkg::t_res o_res
);

    typedef enum logic [pbs_pkg::PHASE_W-1:0] {
        PH_OFF   = 3'd0,
        PH_OPEN  = 3'd1,
        PH_RUN   = 3'd2,
        PH_DELAY = 3'd3,
        PH_LOCK  = 3'd4
    } t_phase;

    t_phase                      r_phase,   n_phase;
    logic [pbs_pkg::CNT_W-1:0]   r_open,    n_open;
    logic [pbs_pkg::CNT_W-1:0]   r_hold,    n_hold;
    logic [pbs_pkg::CNT_W-1:0]   r_close,   n_close;
    logic [pbs_pkg::CNT_W-1:0]   r_delay,   n_delay;
    logic [pbs_pkg::FORCE_W-1:0] r_force,   n_force;
    logic                        r_running, n_running;
    logic                        r_reached, n_reached;
    logic                        r_consumed, n_consumed;
    logic                        r_closing, n_closing;
    logic                        r_armed,   n_armed;
    logic                        r_enable,  n_enable;
    logic                        r_supply,  n_supply;

    logic run;
    logic shut;
    logic cut;
    logic done;
    logic was_closing;
    logic just_armed;

    always_comb begin
        n_phase    = r_phase;
        n_open     = r_open;
        n_hold     = r_hold;
        n_close    = r_close;
        n_delay    = r_delay;
        n_force    = r_force;
        n_running  = r_running;
        n_reached  = r_reached;
        n_consumed = r_consumed;
        n_closing  = r_closing;
        n_armed    = r_armed;
        n_enable   = r_enable;
        n_supply   = r_supply;
        run         = 1'b0;
        shut        = 1'b0;
        cut         = 1'b0;
        done        = 1'b0;
        was_closing = 1'b0;
        just_armed  = 1'b0;

        case (r_phase)
            PH_OPEN: begin
                n_open = pbs_pkg::sat_inc16(r_open);
                if (n_open >= i_cfg.open_pulse_ticks) begin
                    n_enable = 1'b1;
                    done     = 1'b1;
                    n_phase  = PH_RUN;
                    run      = 1'b1;
                end
            end
            PH_RUN: begin
                run = 1'b1;
            end
            PH_DELAY: begin
                n_delay = pbs_pkg::sat_inc16(r_delay);
                if (n_delay >= i_cfg.off_delay_ticks) begin
                    cut = 1'b1;
                end
            end
            PH_LOCK: begin
                n_delay = pbs_pkg::sat_inc16(r_delay);
                if (n_delay >= i_cfg.lockout_ticks) begin
                    n_phase = PH_OFF;
                end
            end
            default: begin
                n_phase = PH_OFF;
                if (i_key_level) begin
                    n_supply = 1'b1;
                    n_enable = 1'b0;
                    n_open   = '0;
                    n_phase  = PH_OPEN;
                end
            end
        endcase

        if (run) begin
            if (i_pc_off_level) begin
                shut = 1'b1;
            end else begin
                if (i_key_level && !n_consumed) begin
                    if (!n_running) begin
                        n_running = 1'b1;
                        n_hold    = '0;
                    end else begin
                        n_hold = pbs_pkg::sat_inc16(n_hold);
                    end
                    if (n_hold >= i_cfg.key_hold_ticks) begin
                        n_running = 1'b0;
                        n_reached = 1'b1;
                    end
                end else if (!i_key_level) begin
                    n_running  = 1'b0;
                    n_consumed = 1'b0;
                end
                was_closing = n_closing;
                if (n_reached && !i_key_level) begin
                    n_reached  = 1'b0;
                    n_consumed = 1'b1;
                    n_closing  = 1'b1;
                    n_armed    = 1'b1;
                    n_force    = '0;
                    just_armed = 1'b1;
                end
                if (n_closing) begin
                    n_enable = 1'b0;
                    n_close  = was_closing ? pbs_pkg::sat_inc16(n_close) : '0;
                    if (n_close >= i_cfg.close_pulse_ticks) begin
                        n_enable  = 1'b1;
                        n_closing = 1'b0;
                    end
                end
                if (n_armed) begin
                    if (!just_armed) begin
                        n_force = pbs_pkg::sat_inc18(n_force);
                    end
                    if (n_force >= i_cfg.force_off_ticks) begin
                        shut = 1'b1;
                    end
                end
            end
        end

        if (shut) begin
            n_running  = 1'b0;
            n_reached  = 1'b0;
            n_consumed = 1'b0;
            n_closing  = 1'b0;
            n_armed    = 1'b0;
            n_hold     = '0;
            n_close    = '0;
            n_force    = '0;
            n_open     = '0;
            n_delay    = '0;
            n_phase    = PH_DELAY;
            if (i_cfg.off_delay_ticks == '0) begin
                cut = 1'b1;
            end
        end

        if (cut) begin
            n_supply = 1'b0;
            n_delay  = '0;
            n_phase  = (i_cfg.lockout_ticks == '0) ? PH_OFF : PH_LOCK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_OFF;
            r_open     <= '0;
            r_hold     <= '0;
            r_close    <= '0;
            r_delay    <= '0;
            r_force    <= '0;
            r_running  <= 1'b0;
            r_reached  <= 1'b0;
            r_consumed <= 1'b0;
            r_closing  <= 1'b0;
            r_armed    <= 1'b0;
            r_enable   <= 1'b1;
            r_supply   <= 1'b0;
        end else if (i_adv) begin
            r_phase    <= n_phase;
            r_open     <= n_open;
            r_hold     <= n_hold;
            r_close    <= n_close;
            r_delay    <= n_delay;
            r_force    <= n_force;
            r_running  <= n_running;
            r_reached  <= n_reached;
            r_consumed <= n_consumed;
            r_closing  <= n_closing;
            r_armed    <= n_armed;
            r_enable   <= n_enable;
            r_supply   <= n_supply;
        end
    end

    assign o_res.pc_enable_level = n_enable;
    assign o_res.supply_on       = n_supply;
    assign o_res.open_done       = done;
    assign o_res.phase           = n_phase;

    `PBS_ASSERT_ALWAYS(a_supply_phase,
        r_supply == (r_phase == PH_OPEN || r_phase == PH_RUN || r_phase == PH_DELAY),
        "supply level disagrees with phase")
    `PBS_ASSERT_ALWAYS(a_closing_running, !r_closing || r_phase == PH_RUN,
        "close pulse outside running phase")
    `PBS_ASSERT_ALWAYS(a_open_line_low, r_phase != PH_OPEN || !r_enable,
        "enable line high during open pulse")

endmodule

>>> sv/pc_power_button_sequencer_top.sv
// PC power button sequencer.
// Input channel: one word per one-millisecond tick, carrying the power key
// level and the PC-off level (i_in_valid / o_in_ready).
// Output channel: one word per input word, carrying the enable line level,
// supply enable, the open-done mark and the phase (o_out_valid / i_out_ready).
// Configuration: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_index;
// write only while no word is in flight.
// An accepted word waits in the input register and passes into the result
// register when that register is empty or its word is being taken. Throughput:
// one word per cycle while the receiver does not stall, set by the single pass
// of counter and flag logic between the two registers.
// When the receiver stalls, the result register holds its word, the input
// register takes one more word and then o_in_ready drops until the output
// drains. Reset empties both registers, restores the register defaults and
// returns the sequencer to off, enable line high, supply off.
`include "pc_power_button_sequencer_top_assert.svh"

module pc_power_button_sequencer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_key_level,
    input  logic                           i_pc_off_level,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_pc_enable_level,
    output logic                           o_supply_on,
    output logic                           o_open_done,
    output logic [pbs_pkg::PHASE_W-1:0]    o_phase,
    input  logic                           i_cfg_wr_en,
    input  logic [pbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pbs_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    pbs_pkg::t_cfg cfg;
    pbs_pkg::t_res res;

    logic          r_in_valid;
    logic          r_in_key;
    logic          r_in_pc_off;
    logic          r_out_valid;
    pbs_pkg::t_res r_out;
    logic          adv;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    pbs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pbs_step u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_key_level    (r_in_key),
        .i_pc_off_level (r_in_pc_off),
        .i_cfg          (cfg),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_key    <= i_key_level;
            r_in_pc_off <= i_pc_off_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pc_enable_level = r_out.pc_enable_level;
    assign o_supply_on       = r_out.supply_on;
    assign o_open_done       = r_out.open_done;
    assign o_phase           = r_out.phase;

    `PBS_ASSERT_NEXT(a_adv_fills_out, adv, r_out_valid,
        "advanced word missing from result register")
    `PBS_ASSERT_ALWAYS(a_ready_when_empty, r_in_valid || o_in_ready,
        "input stalled while input register empty")

endmodule
